/* design/hyperedge_contract_dedupe_macros.svh */
// ----------------------------------------------------------------------------
// hyperedge contraction assertion macros
// shared property shorthands, sampled on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef HYPEREDGE_CONTRACT_DEDUPE_MACROS_SVH
`define HYPEREDGE_CONTRACT_DEDUPE_MACROS_SVH

// same-cycle implication
`define HCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hcd_pkg.sv */
// ----------------------------------------------------------------------------
// hcd_pkg
// shared types, codes and defaults of the hyperedge contraction block
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int unsigned FINE_VERTS_DEF   = 65536;
  localparam int unsigned COARSE_VERTS_DEF = 4096;
  localparam int unsigned MAX_EDGES_DEF    = 1024;
  localparam int unsigned MAX_PINS_DEF     = 8192;
  localparam int unsigned MAX_EDGE_LEN_DEF = 32;

  typedef enum logic [1:0] {
    REQ_MAP  = 2'd0,
    REQ_PIN  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_ACK     = 3'd0,
    ST_KEPT    = 3'd1,
    ST_MERGED  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_PIN     = 3'd4,
    ST_OVF     = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LATCH,
    OP_MAP_WR,
    OP_MAP_RD,
    OP_INSERT,
    OP_SET_OVF,
    OP_HEAD_RD,
    OP_HEAD_LAT,
    OP_I_CLR,
    OP_ES_LO,
    OP_ES_HI,
    OP_ES_LAT,
    OP_PIN_RD,
    OP_PIN_CMP,
    OP_NEXT_RD,
    OP_NEXT_LAT,
    OP_WT_RD,
    OP_MERGE,
    OP_STORE_PIN,
    OP_STORE_FIN,
    OP_RD_SET,
    OP_WT_LAT,
    OP_EMIT,
    OP_EMIT_PIN
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e code;
    logic    clr_buf;
    logic    last;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic fv_ok;
    logic last_pin;
    logic lost;
    logic ovf;
    logic len_lt2;
    logic e_live;
    logic len_match;
    logic pin_eq;
    logic i_last;
    logic st_last;
    logic cap_ok;
    logic rd_ok;
    logic clr_done;
    logic out_free;
  } stat_t;

endpackage

/* design/hcd_if.sv */
// ----------------------------------------------------------------------------
// hcd channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface hcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] fine_vertex;
  logic [11:0] coarse_vertex;
  logic [15:0] edge_weight;
  logic        last_pin;
  logic [9:0]  which_edge;

  modport source (output valid, req_type, fine_vertex, coarse_vertex, edge_weight,
                  last_pin, which_edge, input ready);
  modport sink (input valid, req_type, fine_vertex, coarse_vertex, edge_weight,
                last_pin, which_edge, output ready);
endinterface

interface hcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  edge_index;
  logic [11:0] pin_vertex;
  logic [31:0] weight_out;
  logic [10:0] edge_count;
  logic [13:0] pin_count;
  logic        last_item;

  modport source (output valid, status, edge_index, pin_vertex, weight_out, edge_count,
                  pin_count, last_item, input ready);
  modport sink (input valid, status, edge_index, pin_vertex, weight_out, edge_count,
                pin_count, last_item, output ready);
endinterface

/* design/hyperedge_contract_dedupe.sv */
// ----------------------------------------------------------------------------
// hyperedge_contract_dedupe
// contracts fine hyperedges onto coarse vertices and stores each distinct one
// ----------------------------------------------------------------------------
// in_i carries requests: map loads, pins of the current edge, edge reads.
// out_o returns results, one per request, or one per pin on a read,
// with last_item set on the final result of a request.
// After reset the bucket heads are swept, one entry a cycle, over all
// COARSE_VERTS entries (4096 by default); in_i.ready stays low meanwhile.
// One request is in flight at a time. A map load writes one map entry; a
// plain pin reads the map and inserts its coarse vertex into the sorted
// edge buffer. A last pin walks the bucket of its first vertex, comparing
// each stored edge visited pin by pin, then stores the pins of a new edge.
// A read returns the stored pins of an edge, one result per pin. The walk is
// sequential: each store has a single read port, used one word at a time.
// A result waits in the output register while out_o.ready is low; the next
// request may be taken in, but it stalls when its own result is due.
// ----------------------------------------------------------------------------
module hyperedge_contract_dedupe #(
  parameter int unsigned FINE_VERTS   = hcd_pkg::FINE_VERTS_DEF,
  parameter int unsigned COARSE_VERTS = hcd_pkg::COARSE_VERTS_DEF,
  parameter int unsigned MAX_EDGES    = hcd_pkg::MAX_EDGES_DEF,
  parameter int unsigned MAX_PINS     = hcd_pkg::MAX_PINS_DEF,
  parameter int unsigned MAX_EDGE_LEN = hcd_pkg::MAX_EDGE_LEN_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  hcd_in_if.sink    in_i,
  hcd_out_if.source out_o
);
  import hcd_pkg::*;

  cmd_t  cmd;
  stat_t st;

  hcd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .st_i(st), .cmd_o(cmd)
  );

  hcd_dp #(
    .FINE_VERTS(FINE_VERTS), .COARSE_VERTS(COARSE_VERTS), .MAX_EDGES(MAX_EDGES),
    .MAX_PINS(MAX_PINS), .MAX_EDGE_LEN(MAX_EDGE_LEN)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .st_o(st),
    .req_type_i(in_i.req_type), .fine_vertex_i(in_i.fine_vertex),
    .coarse_vertex_i(in_i.coarse_vertex), .edge_weight_i(in_i.edge_weight),
    .last_pin_i(in_i.last_pin), .which_edge_i(in_i.which_edge),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .status_o(out_o.status), .edge_index_o(out_o.edge_index),
    .pin_vertex_o(out_o.pin_vertex), .weight_out_o(out_o.weight_out),
    .edge_count_o(out_o.edge_count), .pin_count_o(out_o.pin_count),
    .last_item_o(out_o.last_item)
  );
endmodule

/* design/hcd_ram.sv */
// ----------------------------------------------------------------------------
// hcd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* design/hcd_ctrl.sv */
// ----------------------------------------------------------------------------
// hcd_ctrl
// sequencer: clearing pass, map load, pin insert, bucket walk, store, read
// ----------------------------------------------------------------------------
module hcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hcd_pkg::stat_t st_i,
  output hcd_pkg::cmd_t  cmd_o
);
  import hcd_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_MAP_WR, S_PIN_MAP, S_PIN_INS, S_PIN_POST,
    S_HEAD_RD, S_HEAD_LAT, S_CHK, S_ES_LO, S_ES_HI, S_ES_LAT, S_LEN,
    S_CMP_RD, S_CMP, S_NXT_RD, S_NXT_LAT, S_WT_RD, S_MERGE, S_CAP,
    S_ST_PIN, S_ST_FIN, S_RWT_RD, S_RWT_LAT, S_RP_RD, S_RP_EMIT, S_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    clr_q, clr_d;
  logic    rdm_q, rdm_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    clr_d   = clr_q;
    rdm_d   = rdm_q;
    cmd_o   = '{op: OP_NONE, code: code_q, clr_buf: clr_q, last: 1'b1};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLR;
        if (st_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        clr_d = 1'b0;
        rdm_d = 1'b0;
        unique case (st_i.req)
          REQ_MAP:  state_d = S_MAP_WR;
          REQ_PIN:  state_d = st_i.fv_ok ? S_PIN_MAP : S_PIN_POST;
          REQ_READ: begin
            rdm_d = 1'b1;
            if (st_i.rd_ok) begin
              cmd_o.op = OP_RD_SET;
              state_d  = S_ES_LO;
            end else begin
              code_d  = ST_OVF;
              state_d = S_EMIT;
            end
          end
          default: begin
            code_d  = ST_ACK;
            state_d = S_EMIT;
          end
        endcase
      end
      S_MAP_WR: begin
        cmd_o.op = OP_MAP_WR;
        code_d   = ST_ACK;
        state_d  = S_EMIT;
      end
      S_PIN_MAP: begin
        cmd_o.op = OP_MAP_RD;
        state_d  = S_PIN_INS;
      end
      S_PIN_INS: begin
        cmd_o.op = OP_INSERT;
        state_d  = S_PIN_POST;
      end
      S_PIN_POST: begin
        if (!st_i.last_pin) begin
          cmd_o.op = OP_SET_OVF;
          code_d   = st_i.lost ? ST_OVF : ST_ACK;
          state_d  = S_EMIT;
        end else if (st_i.ovf || st_i.lost) begin
          code_d  = ST_OVF;
          clr_d   = 1'b1;
          state_d = S_EMIT;
        end else if (st_i.len_lt2) begin
          code_d  = ST_DROPPED;
          clr_d   = 1'b1;
          state_d = S_EMIT;
        end else begin
          clr_d   = 1'b1;
          state_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd_o.op = OP_HEAD_RD;
        state_d  = S_HEAD_LAT;
      end
      S_HEAD_LAT: begin
        cmd_o.op = OP_HEAD_LAT;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_I_CLR;
        state_d  = st_i.e_live ? S_ES_LO : S_CAP;
      end
      S_ES_LO: begin
        cmd_o.op = OP_ES_LO;
        state_d  = S_ES_HI;
      end
      S_ES_HI: begin
        cmd_o.op = OP_ES_HI;
        state_d  = S_ES_LAT;
      end
      S_ES_LAT: begin
        cmd_o.op = OP_ES_LAT;
        state_d  = S_LEN;
      end
      S_LEN: begin
        if (rdm_q) state_d = S_RWT_RD;
        else       state_d = st_i.len_match ? S_CMP_RD : S_NXT_RD;
      end
      S_CMP_RD: begin
        cmd_o.op = OP_PIN_RD;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_PIN_CMP;
        if (!st_i.pin_eq)     state_d = S_NXT_RD;
        else if (st_i.i_last) state_d = S_WT_RD;
        else                  state_d = S_CMP_RD;
      end
      S_NXT_RD: begin
        cmd_o.op = OP_NEXT_RD;
        state_d  = S_NXT_LAT;
      end
      S_NXT_LAT: begin
        cmd_o.op = OP_NEXT_LAT;
        state_d  = S_CHK;
      end
      S_WT_RD: begin
        cmd_o.op = OP_WT_RD;
        state_d  = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.op = OP_MERGE;
        code_d   = ST_MERGED;
        state_d  = S_EMIT;
      end
      S_CAP: begin
        if (st_i.cap_ok) begin
          state_d = S_ST_PIN;
        end else begin
          code_d  = ST_OVF;
          state_d = S_EMIT;
        end
      end
      S_ST_PIN: begin
        cmd_o.op = OP_STORE_PIN;
        if (st_i.st_last) state_d = S_ST_FIN;
      end
      S_ST_FIN: begin
        cmd_o.op = OP_STORE_FIN;
        code_d   = ST_KEPT;
        state_d  = S_EMIT;
      end
      S_RWT_RD: begin
        cmd_o.op = OP_WT_RD;
        state_d  = S_RWT_LAT;
      end
      S_RWT_LAT: begin
        cmd_o.op = OP_WT_LAT;
        state_d  = S_RP_RD;
      end
      S_RP_RD: begin
        cmd_o.op = OP_PIN_RD;
        state_d  = S_RP_EMIT;
      end
      S_RP_EMIT: begin
        // one result per stored pin, waits on the output slot
        if (st_i.out_free) begin
          cmd_o.op   = OP_EMIT_PIN;
          cmd_o.last = st_i.i_last;
          state_d    = st_i.i_last ? S_IDLE : S_RP_RD;
        end
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= ST_ACK;
      clr_q   <= 1'b0;
      rdm_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      clr_q   <= clr_d;
      rdm_q   <= rdm_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

/* design/hcd_dp.sv */
// ----------------------------------------------------------------------------
// hcd_dp
// datapath: edge buffer, vertex map, edge store, bucket lists, result register
// ----------------------------------------------------------------------------
module hcd_dp #(
  parameter int unsigned FINE_VERTS   = hcd_pkg::FINE_VERTS_DEF,
  parameter int unsigned COARSE_VERTS = hcd_pkg::COARSE_VERTS_DEF,
  parameter int unsigned MAX_EDGES    = hcd_pkg::MAX_EDGES_DEF,
  parameter int unsigned MAX_PINS     = hcd_pkg::MAX_PINS_DEF,
  parameter int unsigned MAX_EDGE_LEN = hcd_pkg::MAX_EDGE_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hcd_pkg::cmd_t  cmd_i,
  output hcd_pkg::stat_t st_o,
  input  logic [1:0]     req_type_i,
  input  logic [15:0]    fine_vertex_i,
  input  logic [11:0]    coarse_vertex_i,
  input  logic [15:0]    edge_weight_i,
  input  logic           last_pin_i,
  input  logic [9:0]     which_edge_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output logic [9:0]     edge_index_o,
  output logic [11:0]    pin_vertex_o,
  output logic [31:0]    weight_out_o,
  output logic [10:0]    edge_count_o,
  output logic [13:0]    pin_count_o,
  output logic           last_item_o
);
  import hcd_pkg::*;

  localparam int unsigned FAW  = $clog2(FINE_VERTS);
  localparam int unsigned CW   = $clog2(COARSE_VERTS);
  localparam int unsigned EW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned PW   = $clog2(MAX_PINS + 1);
  localparam int unsigned PAW  = $clog2(MAX_PINS);
  localparam int unsigned LW   = $clog2(MAX_EDGE_LEN + 1);
  localparam int unsigned LAW  = $clog2(MAX_EDGE_LEN);

  // latched request
  req_e        req_q;
  logic [15:0] fv_q;
  logic [11:0] cv_q;
  logic [15:0] wt_q;
  logic        last_q;
  logic [9:0]  which_q;

  logic [CW-1:0]  buf_q [MAX_EDGE_LEN];
  logic [CW-1:0]  ins_buf [MAX_EDGE_LEN];
  logic [MAX_EDGE_LEN-1:0] lt, eq;
  logic [LW-1:0]  len_q;
  logic           ovf_q, lost_q;
  logic [EW-1:0]  e_q, head_q, idx_q, se_q;
  logic [PW-1:0]  s_q, end_q, sp_q;
  logic [LAW-1:0] i_q;
  logic [31:0]    wout_q;
  logic [CW-1:0]  clr_q;
  logic           es_zero_q;

  logic           out_valid_q, last_item_q;
  status_e        out_status_q;
  logic [EW-1:0]  out_idx_q;
  logic [CW-1:0]  out_pin_q;
  logic [31:0]    out_wt_q;
  logic [EW-1:0]  out_ec_q;
  logic [PW-1:0]  out_pc_q;

  // ram ports
  logic           map_we, map_re;
  logic [CW-1:0]  map_rdata;
  logic [31:0]    fv_ext, cv_sat;
  logic           head_we, head_re;
  logic [CW-1:0]  head_waddr;
  logic [EW-1:0]  head_wdata, head_rdata;
  logic           es_we, es_re;
  logic [EW-1:0]  es_raddr;
  logic [PW-1:0]  es_rdata, es_val, es_wdata;
  logic [EW-1:0]  se_inc;
  logic           pin_we, pin_re;
  logic [31:0]    pin_raddr32, pin_waddr32;
  logic [CW-1:0]  pin_rdata;
  logic           wt_we, wt_re;
  logic [31:0]    wt_rdata, wt_wdata;
  logic [32:0]    wt_sum;
  logic [31:0]    wt_sat;
  logic           nx_we, nx_re;
  logic [EW-1:0]  nx_rdata;
  logic [31:0]    which_ext;
  logic           any_eq, full;

  assign fv_ext    = 32'(fv_q);
  assign cv_sat    = (32'(cv_q) < COARSE_VERTS) ? 32'(cv_q) : COARSE_VERTS - 1;
  assign which_ext = 32'(which_q);
  assign se_inc    = se_q + EW'(1);

  // sorted insert: every slot picks its own neighbour in parallel
  for (genvar g = 0; g < MAX_EDGE_LEN; g++) begin : g_ins
    assign lt[g] = (32'(len_q) > g) && (buf_q[g] < map_rdata);
    assign eq[g] = (32'(len_q) > g) && (buf_q[g] == map_rdata);
    if (g == 0) begin : g_first
      assign ins_buf[g] = lt[g] ? buf_q[g] : map_rdata;
    end else begin : g_rest
      assign ins_buf[g] = lt[g] ? buf_q[g] : (lt[g-1] ? map_rdata : buf_q[g-1]);
    end
  end
  assign any_eq = |eq;
  assign full   = (32'(len_q) == MAX_EDGE_LEN);

  assign es_val = es_zero_q ? '0 : es_rdata;
  assign wt_sum = {1'b0, wt_rdata} + 33'(wt_q);
  assign wt_sat = wt_sum[32] ? '1 : wt_sum[31:0];

  // ram control
  assign map_we      = (cmd_i.op == OP_MAP_WR) && (fv_ext < FINE_VERTS);
  assign map_re      = (cmd_i.op == OP_MAP_RD);
  assign head_we     = (cmd_i.op == OP_CLR) || (cmd_i.op == OP_STORE_FIN);
  assign head_waddr  = (cmd_i.op == OP_CLR) ? clr_q : buf_q[0];
  assign head_wdata  = (cmd_i.op == OP_CLR) ? EW'(MAX_EDGES) : se_q;
  assign head_re     = (cmd_i.op == OP_HEAD_RD);
  assign es_re       = (cmd_i.op == OP_ES_LO) || (cmd_i.op == OP_ES_HI);
  assign es_raddr    = (cmd_i.op == OP_ES_HI) ? e_q + EW'(1) : e_q;
  assign es_we       = (cmd_i.op == OP_STORE_FIN);
  assign es_wdata    = sp_q + PW'(len_q);
  assign pin_re      = (cmd_i.op == OP_PIN_RD);
  assign pin_raddr32 = 32'(s_q) + 32'(i_q);
  assign pin_we      = (cmd_i.op == OP_STORE_PIN);
  assign pin_waddr32 = 32'(sp_q) + 32'(i_q);
  assign wt_re       = (cmd_i.op == OP_WT_RD);
  assign wt_we       = (cmd_i.op == OP_MERGE) || (cmd_i.op == OP_STORE_FIN);
  assign wt_wdata    = (cmd_i.op == OP_MERGE) ? wt_sat : 32'(wt_q);
  assign nx_re       = (cmd_i.op == OP_NEXT_RD);
  assign nx_we       = (cmd_i.op == OP_STORE_FIN);

  hcd_ram #(.Width(CW), .Depth(FINE_VERTS)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(fv_ext[FAW-1:0]), .wdata_i(cv_sat[CW-1:0]),
    .re_i(map_re), .raddr_i(fv_ext[FAW-1:0]), .rdata_o(map_rdata)
  );

  hcd_ram #(.Width(EW), .Depth(COARSE_VERTS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(buf_q[0]), .rdata_o(head_rdata)
  );

  hcd_ram #(.Width(PW), .Depth(MAX_EDGES + 1)) u_start (
    .clk_i, .we_i(es_we), .waddr_i(se_inc), .wdata_i(es_wdata),
    .re_i(es_re), .raddr_i(es_raddr), .rdata_o(es_rdata)
  );

  hcd_ram #(.Width(CW), .Depth(MAX_PINS)) u_pins (
    .clk_i, .we_i(pin_we), .waddr_i(pin_waddr32[PAW-1:0]), .wdata_i(buf_q[i_q]),
    .re_i(pin_re), .raddr_i(pin_raddr32[PAW-1:0]), .rdata_o(pin_rdata)
  );

  hcd_ram #(.Width(32), .Depth(MAX_EDGES)) u_wts (
    .clk_i, .we_i(wt_we), .waddr_i((cmd_i.op == OP_MERGE) ? e_q[EAW-1:0] : se_q[EAW-1:0]),
    .wdata_i(wt_wdata), .re_i(wt_re), .raddr_i(e_q[EAW-1:0]), .rdata_o(wt_rdata)
  );

  hcd_ram #(.Width(EW), .Depth(MAX_EDGES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(se_q[EAW-1:0]), .wdata_i(head_q),
    .re_i(nx_re), .raddr_i(e_q[EAW-1:0]), .rdata_o(nx_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      se_q        <= '0;
      sp_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT || cmd_i.op == OP_EMIT_PIN) out_valid_q <= 1'b1;
      else if (out_ready_i)                               out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_CLR: clr_q <= clr_q + CW'(1);
        OP_INSERT: begin
          if (!any_eq && !full) len_q <= len_q + LW'(1);
        end
        OP_SET_OVF: ovf_q <= ovf_q | lost_q;
        OP_STORE_FIN: begin
          se_q <= se_inc;
          sp_q <= es_wdata;
        end
        OP_EMIT: begin
          if (cmd_i.clr_buf) begin
            len_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        req_q   <= req_e'(req_type_i);
        fv_q    <= fine_vertex_i;
        cv_q    <= coarse_vertex_i;
        wt_q    <= edge_weight_i;
        last_q  <= last_pin_i;
        which_q <= which_edge_i;
        lost_q  <= 1'b0;
      end
      OP_INSERT: begin
        if (!any_eq) begin
          if (full) lost_q <= 1'b1;
          else      buf_q  <= ins_buf;
        end
      end
      OP_HEAD_LAT: begin
        e_q    <= head_rdata;
        head_q <= head_rdata;
      end
      OP_I_CLR: i_q <= '0;
      OP_ES_HI: es_zero_q <= (es_raddr == '0);
      OP_ES_LAT: begin
        end_q <= es_val;
        i_q   <= '0;
      end
      OP_PIN_CMP, OP_STORE_PIN: i_q <= i_q + LAW'(1);
      OP_NEXT_LAT: e_q <= nx_rdata;
      OP_MERGE: begin
        wout_q <= wt_sat;
        idx_q  <= e_q;
      end
      OP_STORE_FIN: begin
        wout_q <= 32'(wt_q);
        idx_q  <= se_q;
      end
      OP_RD_SET: e_q <= which_ext[EW-1:0];
      OP_WT_LAT: begin
        wout_q <= wt_rdata;
        idx_q  <= e_q;
      end
      OP_EMIT: begin
        out_status_q <= cmd_i.code;
        last_item_q  <= 1'b1;
        out_pin_q    <= '0;
        out_ec_q     <= se_q;
        out_pc_q     <= sp_q;
        if (cmd_i.code == ST_KEPT || cmd_i.code == ST_MERGED) begin
          out_idx_q <= idx_q;
          out_wt_q  <= wout_q;
        end else begin
          out_idx_q <= '0;
          out_wt_q  <= '0;
        end
      end
      OP_EMIT_PIN: begin
        out_status_q <= ST_PIN;
        last_item_q  <= cmd_i.last;
        out_pin_q    <= pin_rdata;
        out_idx_q    <= idx_q;
        out_wt_q     <= wout_q;
        out_ec_q     <= se_q;
        out_pc_q     <= sp_q;
        i_q          <= i_q + LAW'(1);
      end
      default: ;
    endcase
    // start offset is taken the cycle after its read
    if (cmd_i.op == OP_ES_HI) s_q <= es_val;
    if (cmd_i.op == OP_ES_LO) es_zero_q <= (es_raddr == '0);
  end

  always_comb begin
    st_o.req       = req_q;
    st_o.fv_ok     = fv_ext < FINE_VERTS;
    st_o.last_pin  = last_q;
    st_o.lost      = lost_q;
    st_o.ovf       = ovf_q;
    st_o.len_lt2   = len_q < LW'(2);
    st_o.e_live    = 32'(e_q) < 32'(se_q);
    st_o.len_match = (32'(end_q) - 32'(s_q)) == 32'(len_q);
    st_o.pin_eq    = pin_rdata == buf_q[i_q];
    // against the stored edge length, for compare and read
    st_o.i_last    = (32'(i_q) + 32'd1) == (32'(end_q) - 32'(s_q));
    // against the buffer length, for the store of a new edge
    st_o.st_last   = (32'(i_q) + 32'd1) == 32'(len_q);
    st_o.cap_ok    = (32'(se_q) < MAX_EDGES) && (MAX_PINS - 32'(sp_q) >= 32'(len_q));
    st_o.rd_ok     = which_ext < 32'(se_q);
    st_o.clr_done  = 32'(clr_q) == COARSE_VERTS - 1;
    st_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign edge_index_o = 10'(out_idx_q);
  assign pin_vertex_o = 12'(out_pin_q);
  assign weight_out_o = out_wt_q;
  assign edge_count_o = 11'(out_ec_q);
  assign pin_count_o  = 14'(out_pc_q);
  assign last_item_o  = last_item_q;
endmodule

/* design/hcd_checker.sv */
// ----------------------------------------------------------------------------
// hcd_checker
// port-level checks of the hyperedge contraction block
// ----------------------------------------------------------------------------
`include "hyperedge_contract_dedupe_macros.svh"

module hcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [9:0]  edge_index_i,
  input logic [10:0] edge_count_i
);
  import hcd_pkg::*;

  `HCD_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result lost while stalled")
  `HCD_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i, "request taken while busy")
  `HCD_ASSERT_IMP(a_status_range, out_valid_i, status_i <= ST_OVF, "status code out of range")
  `HCD_ASSERT_IMP(a_kept_index, out_valid_i && status_i == ST_KEPT, 11'(edge_index_i) + 11'd1 == edge_count_i, "kept edge index not newest")
  `HCD_ASSERT_IMP(a_read_index, out_valid_i && status_i == ST_PIN, 11'(edge_index_i) < edge_count_i, "read of an unstored edge")
endmodule

bind hyperedge_contract_dedupe hcd_checker u_hcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .edge_index_i (out_o.edge_index),
  .edge_count_i (out_o.edge_count)
);

/* dv/hyperedge_contract_dedupe_tb.sv */
// ----------------------------------------------------------------------------
// hyperedge_contract_dedupe_tb
// drives map loads, hyperedge pins, edge reads and REQ_NONE requests into the
// contraction block, predicts each result from a local model of the edge store
// and compares every result transaction in order, with random stalls on both channels
// ----------------------------------------------------------------------------
typedef struct {
  logic [2:0]  status;
  logic [9:0]  edge_index;
  logic [11:0] pin_vertex;
  logic [31:0] weight_out;
  logic [10:0] edge_count;
  logic [13:0] pin_count;
  logic        last_item;
} hcd_result_t;

class contraction_scoreboard;
  localparam int unsigned NEDGES = hcd_pkg::MAX_EDGES_DEF;
  localparam int unsigned NPINS  = hcd_pkg::MAX_PINS_DEF;
  localparam int unsigned ELEN   = hcd_pkg::MAX_EDGE_LEN_DEF;

  logic [11:0]  coarse_of [hcd_pkg::FINE_VERTS_DEF];
  int unsigned  edge_pins [$];
  bit           pins_lost;
  logic [11:0]  pin_store [NPINS];
  int unsigned  edge_base [NEDGES+1];
  logic [31:0]  edge_wt [NEDGES];
  int unsigned  bucket_head [hcd_pkg::COARSE_VERTS_DEF];
  int unsigned  bucket_link [NEDGES];
  int unsigned  n_edges;
  int unsigned  n_pins;
  hcd_result_t  pending [$];
  int unsigned  errors;

  function new();
    foreach (bucket_head[i]) bucket_head[i] = NEDGES;
    edge_base[0] = 0;
    n_edges = 0;
    n_pins = 0;
    pins_lost = 0;
    errors = 0;
  endfunction

  function void expect_result(logic [2:0] st, int unsigned idx, int unsigned pv,
                              logic [31:0] wt, bit last);
    hcd_result_t r;
    r.status = st;
    r.edge_index = idx[9:0];
    r.pin_vertex = pv[11:0];
    r.weight_out = wt;
    r.edge_count = n_edges[10:0];
    r.pin_count = n_pins[13:0];
    r.last_item = last;
    pending.push_back(r);
  endfunction

  // false when the vertex is new and the buffer is already full
  function bit add_pin(int unsigned v);
    int unsigned p;
    p = 0;
    while (p < edge_pins.size() && edge_pins[p] < v) p++;
    if (p < edge_pins.size() && edge_pins[p] == v) return 1;
    if (edge_pins.size() >= ELEN) return 0;
    edge_pins.insert(p, v);
    return 1;
  endfunction

  function bit matches_stored(int unsigned e);
    int unsigned s;
    s = edge_base[e];
    if (edge_base[e+1] - s != edge_pins.size()) return 0;
    foreach (edge_pins[i]) if (pin_store[s+i] != edge_pins[i]) return 0;
    return 1;
  endfunction

  function void close_edge(logic [15:0] wt, bit lost);
    int unsigned first, e, steps;
    logic [32:0] sum;
    if (pins_lost || lost) begin
      expect_result(hcd_pkg::ST_OVF, 0, 0, 0, 1);
      return;
    end
    if (edge_pins.size() < 2) begin
      expect_result(hcd_pkg::ST_DROPPED, 0, 0, 0, 1);
      return;
    end
    first = edge_pins[0];
    e = bucket_head[first];
    steps = 0;
    while (e < NEDGES && e < n_edges && steps <= n_edges) begin
      if (matches_stored(e)) begin
        sum = {1'b0, edge_wt[e]} + wt;
        edge_wt[e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        expect_result(hcd_pkg::ST_MERGED, e, 0, edge_wt[e], 1);
        return;
      end
      e = bucket_link[e];
      steps++;
    end
    if (n_edges >= NEDGES || NPINS - n_pins < edge_pins.size()) begin
      expect_result(hcd_pkg::ST_OVF, 0, 0, 0, 1);
      return;
    end
    e = n_edges;
    foreach (edge_pins[i]) pin_store[n_pins+i] = edge_pins[i];
    n_pins += edge_pins.size();
    edge_base[e+1] = n_pins;
    edge_wt[e] = wt;
    bucket_link[e] = bucket_head[first];
    bucket_head[first] = e;
    n_edges++;
    expect_result(hcd_pkg::ST_KEPT, e, 0, {16'h0, wt}, 1);
  endfunction

  // called once per accepted request transaction
  function void note_request(hcd_pkg::req_e req, logic [15:0] fv, logic [11:0] cv,
                             logic [15:0] wt, logic last, logic [9:0] which);
    bit lost;
    int unsigned s, len;
    case (req)
      hcd_pkg::REQ_MAP: begin
        coarse_of[fv] = cv;
        expect_result(hcd_pkg::ST_ACK, 0, 0, 0, 1);
      end
      hcd_pkg::REQ_PIN: begin
        lost = !add_pin(coarse_of[fv]);
        if (!last) begin
          if (lost) pins_lost = 1;
          expect_result(lost ? hcd_pkg::ST_OVF : hcd_pkg::ST_ACK, 0, 0, 0, 1);
        end else begin
          close_edge(wt, lost);
          edge_pins.delete();
          pins_lost = 0;
        end
      end
      hcd_pkg::REQ_READ: begin
        if (which >= n_edges) begin
          expect_result(hcd_pkg::ST_OVF, 0, 0, 0, 1);
        end else begin
          s = edge_base[which];
          len = edge_base[which+1] - s;
          for (int unsigned i = 0; i < len; i++)
            expect_result(hcd_pkg::ST_PIN, which, pin_store[s+i], edge_wt[which],
                          i + 1 == len);
        end
      end
      default: expect_result(hcd_pkg::ST_ACK, 0, 0, 0, 1);
    endcase
  endfunction

  function void check_result(hcd_result_t got);
    hcd_result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result transaction, status %0d", got.status);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status); errors++;
    end
    if (got.edge_index !== want.edge_index) begin
      $error("edge_index: expected %0d, actual %0d", want.edge_index, got.edge_index);
      errors++;
    end
    if (got.pin_vertex !== want.pin_vertex) begin
      $error("pin_vertex: expected %0d, actual %0d", want.pin_vertex, got.pin_vertex);
      errors++;
    end
    if (got.weight_out !== want.weight_out) begin
      $error("weight_out: expected %0d, actual %0d", want.weight_out, got.weight_out);
      errors++;
    end
    if (got.edge_count !== want.edge_count) begin
      $error("edge_count: expected %0d, actual %0d", want.edge_count, got.edge_count);
      errors++;
    end
    if (got.pin_count !== want.pin_count) begin
      $error("pin_count: expected %0d, actual %0d", want.pin_count, got.pin_count);
      errors++;
    end
    if (got.last_item !== want.last_item) begin
      $error("last_item: expected %0d, actual %0d", want.last_item, got.last_item);
      errors++;
    end
  endfunction
endclass

module hyperedge_contract_dedupe_tb;
  import hcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_ITEMS = 300;

  logic clk_i;
  logic rst_ni;
  hcd_in_if  in_if();
  hcd_out_if out_if();

  contraction_scoreboard sb;
  bit          quiet;
  bit          hold_off;
  int unsigned cycles;
  logic [15:0] mapped [$];   // fine vertices that have been loaded

  hyperedge_contract_dedupe uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 0;
    in_if.valid <= 0;
    in_if.req_type <= REQ_NONE;
    in_if.fine_vertex <= 0;
    in_if.coarse_vertex <= 0;
    in_if.edge_weight <= 0;
    in_if.last_pin <= 0;
    in_if.which_edge <= 0;
    out_if.ready <= 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hyperedge_contract_dedupe regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    hcd_result_t r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.status = out_if.status;
      r.edge_index = out_if.edge_index;
      r.pin_vertex = out_if.pin_vertex;
      r.weight_out = out_if.weight_out;
      r.edge_count = out_if.edge_count;
      r.pin_count = out_if.pin_count;
      r.last_item = out_if.last_item;
      sb.check_result(r);
    end
  end

  // result side stalls, with long hold-offs between items 200 and 205 so the block backs up
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_if.ready <= 0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_if.ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send(req_e req, logic [15:0] fv, logic [11:0] cv, logic [15:0] wt,
                      logic last, logic [9:0] which);
    if (!quiet && $urandom_range(4) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.req_type <= req;
    in_if.fine_vertex <= fv;
    in_if.coarse_vertex <= cv;
    in_if.edge_weight <= wt;
    in_if.last_pin <= last;
    in_if.which_edge <= which;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_request(req, fv, cv, wt, last, which);
  endtask

  task automatic load_map(logic [15:0] fv, logic [11:0] cv);
    send(REQ_MAP, fv, cv, 16'($urandom), 1'($urandom), 10'($urandom));
    if (!(fv inside {mapped})) mapped.push_back(fv);
  endtask

  task automatic pin(logic [15:0] fv, logic last, logic [15:0] wt);
    send(REQ_PIN, fv, 12'($urandom), wt, last, 10'($urandom));
  endtask

  // random edge; a narrow vertex pool makes repeats and merges common
  task automatic random_edge(output int unsigned len);
    int unsigned pool;
    len = $urandom_range(1, 6);
    pool = ($urandom_range(1) == 0) ? 6 : mapped.size();
    for (int unsigned i = 0; i < len; i++)
      pin(mapped[$urandom_range(pool - 1)], i + 1 == len, 16'($urandom));
  endtask

  initial begin
    int unsigned items, pick, n;
    sb = new();
    quiet = 0;
    hold_off = 0;
    cycles = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // distinct coarse ids for the first 40 fine vertices, plus the extremes
    for (int unsigned k = 0; k < 40; k++) load_map(16'(k), 12'((k * 97) % 4096));
    load_map(16'hFFFF, 12'hFFF);
    load_map(16'd40, 12'd0);

    pin(16'd3, 1, 16'hFFFF);                 // single vertex, dropped
    pin(16'd5, 0, 0); pin(16'd5, 1, 16'd9);  // repeated vertex only, dropped
    pin(16'd7, 0, 0); pin(16'hFFFF, 1, 16'hFFFF);
    pin(16'hFFFF, 0, 0); pin(16'd7, 0, 0); pin(16'd7, 1, 16'd0); // merge, reordered
    pin(16'd40, 0, 0); pin(16'd0, 1, 16'd1); // fine 40 and 0 share coarse 0: dropped
    send(REQ_READ, 0, 0, 0, 0, 10'd0);
    send(REQ_READ, 0, 0, 0, 0, 10'h3FF);     // beyond the stored edges
    send(REQ_NONE, 16'hFFFF, 12'hFFF, 16'hFFFF, 1, 10'h3FF);

    // buffer overflow before the last pin, then on the last pin itself
    for (int unsigned k = 0; k < 35; k++) pin(16'(k), k == 34, 16'd5);
    for (int unsigned k = 0; k < 33; k++) pin(16'(k), k == 32, 16'd5);
    // a full-length edge that fits, then read back
    for (int unsigned k = 0; k < 32; k++) pin(16'(k + 1), k == 31, 16'd77);
    send(REQ_READ, 0, 0, 0, 0, 10'(sb.n_edges - 1));

    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items > RANDOM_ITEMS * 85 / 100) quiet = 1;
      if (items >= 200 && items < 206) hold_off = 1;
      pick = $urandom_range(99);
      if (pick < 10) begin
        if ($urandom_range(1) == 0)
          load_map(mapped[$urandom_range(mapped.size() - 1)], 12'($urandom_range(15)));
        else
          load_map(16'($urandom), 12'($urandom));
        items++;
      end else if (pick < 80) begin
        random_edge(n);
        items += n;
      end else if (pick < 95) begin
        if ($urandom_range(4) == 0)
          send(REQ_READ, 16'($urandom), 12'($urandom), 16'($urandom), 1'($urandom),
               10'($urandom));
        else
          send(REQ_READ, 0, 0, 0, 0, 10'($urandom_range(sb.n_edges - 1)));
        items++;
      end else begin
        send(REQ_NONE, 16'($urandom), 12'($urandom), 16'($urandom), 1'($urandom),
             10'($urandom));
        items++;
      end
    end
    in_if.valid <= 0;
    quiet = 1;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("hyperedge_contract_dedupe regression: pass");
    else
      $display("hyperedge_contract_dedupe regression: fail");
    $finish;
  end
endmodule
